/* src/ipmfe_pkg.sv */
`timescale 1ns / 1ps

package ipmfe_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_W       = 11;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned MAC_W       = 48;
  localparam int unsigned IP_W        = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned CFG_DATA_W  = 48;

  localparam int unsigned HDR_BYTES   = 34;
  localparam int unsigned HCNT_W      = $clog2(HDR_BYTES + 1);
  localparam int unsigned ETH_BYTES   = 14;
  localparam int unsigned IP_HDR_LEN  = 20;
  localparam int unsigned MAX_PAYLOAD = 1480;

  // sum of four variable header words plus constant words fits in 19 bits
  localparam int unsigned SUM_W       = 19;

  localparam logic [MAC_W-1:0] DST_MAC     = 48'h01_00_5e_00_00_05;
  localparam logic [15:0]      ETH_TYPE    = 16'h0800;
  localparam logic [7:0]       IP_VER_IHL  = 8'h45;
  localparam logic [7:0]       IP_TOS      = 8'b11000000;
  localparam logic [7:0]       IP_TTL      = 8'h01;
  localparam logic [7:0]       IP_PROTO    = 8'h59;
  localparam logic [IP_W-1:0]  DST_IP      = 32'he0_00_00_05;
  localparam logic [15:0]      CSUM_MASK   = 16'hffff;

  // header words that never change: ver/ihl/tos, ttl/proto, destination
  localparam logic [SUM_W-1:0] CONST_SUM =
    SUM_W'({IP_VER_IHL, IP_TOS}) + SUM_W'({IP_TTL, IP_PROTO}) +
    SUM_W'(DST_IP[31:16]) + SUM_W'(DST_IP[15:0]);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_MAC = 8'd0,
    CFG_SOURCE_IP  = 8'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [LEN_W-1:0] total_len;
    logic [ID_W-1:0]  packet_id;
    logic [SUM_W-1:0] part_sum;
  } hdr_fields_t;

endpackage

/* src/ipmfe_in_if.sv */
`timescale 1ns / 1ps

interface ipmfe_in_if;
  logic                         valid;
  logic                         ready;
  logic [ipmfe_pkg::BYTE_W-1:0] payload_byte;
  logic [ipmfe_pkg::LEN_W-1:0]  payload_length;
  logic [ipmfe_pkg::ID_W-1:0]   packet_id;
  logic                         last_in;

  modport source (output valid, payload_byte, payload_length, packet_id, last_in,
                  input ready);
  modport sink (input valid, payload_byte, payload_length, packet_id, last_in,
                output ready);
endinterface

/* src/ipmfe_out_if.sv */
`timescale 1ns / 1ps

interface ipmfe_out_if;
  logic                         valid;
  logic                         ready;
  logic [ipmfe_pkg::BYTE_W-1:0] frame_byte;
  logic                         is_header;
  logic                         last_out;

  modport source (output valid, frame_byte, is_header, last_out, input ready);
  modport sink (input valid, frame_byte, is_header, last_out, output ready);
endinterface

/* src/ipmfe_cfg_if.sv */
`timescale 1ns / 1ps

interface ipmfe_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ipmfe_pkg::CFG_IDX_W-1:0]  index;
  logic [ipmfe_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/ipmfe_hdr_mux.sv */
`timescale 1ns / 1ps

module ipmfe_hdr_mux (
  input  logic [ipmfe_pkg::HCNT_W-1:0] idx_i,
  input  logic [ipmfe_pkg::MAC_W-1:0]  src_mac_i,
  input  logic [ipmfe_pkg::IP_W-1:0]   src_ip_i,
  input  ipmfe_pkg::hdr_fields_t       fields_i,
  output logic [ipmfe_pkg::BYTE_W-1:0] byte_o
);
  import ipmfe_pkg::*;

  logic [16:0]         fold1;
  logic [15:0]         fold2;
  logic [15:0]         csum;
  logic [15:0]         total;
  logic [BYTE_W-1:0]   hdr [HDR_BYTES];

  // end-around carry, then complement
  always_comb begin
    fold1 = 17'(fields_i.part_sum[SUM_W-1:16]) + 17'(fields_i.part_sum[15:0]);
    fold2 = fold1[15:0] + 16'(fold1[16]);
    csum  = ~fold2 & CSUM_MASK;
    total = 16'(fields_i.total_len);
  end

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      hdr[i]     = DST_MAC[8*(5-i) +: 8];
      hdr[6 + i] = src_mac_i[8*(5-i) +: 8];
    end
    hdr[12] = ETH_TYPE[15:8];
    hdr[13] = ETH_TYPE[7:0];
    hdr[ETH_BYTES + 0]  = IP_VER_IHL;
    hdr[ETH_BYTES + 1]  = IP_TOS;
    hdr[ETH_BYTES + 2]  = total[15:8];
    hdr[ETH_BYTES + 3]  = total[7:0];
    hdr[ETH_BYTES + 4]  = fields_i.packet_id[15:8];
    hdr[ETH_BYTES + 5]  = fields_i.packet_id[7:0];
    hdr[ETH_BYTES + 6]  = '0;
    hdr[ETH_BYTES + 7]  = '0;
    hdr[ETH_BYTES + 8]  = IP_TTL;
    hdr[ETH_BYTES + 9]  = IP_PROTO;
    hdr[ETH_BYTES + 10] = csum[15:8];
    hdr[ETH_BYTES + 11] = csum[7:0];
    for (int i = 0; i < 4; i++) begin
      hdr[ETH_BYTES + 12 + i] = src_ip_i[8*(3-i) +: 8];
      hdr[ETH_BYTES + 16 + i] = DST_IP[8*(3-i) +: 8];
    end
  end

  assign byte_o = (idx_i < HCNT_W'(HDR_BYTES)) ? hdr[idx_i] : '0;

endmodule

/* src/ipv4_multicast_frame_encapsulator.sv */
`timescale 1ns / 1ps

// Wraps a stream of OSPF payload bytes into Ethernet/IPv4 multicast frames
// (destination 01:00:5e:00:00:05 / 224.0.0.5, TTL 1, protocol 89). The first
// payload byte of a packet is held while the 34 header bytes go out, one per
// cycle while the receiver is ready; every later payload byte passes through
// the single output register. Length and id are sampled with the first byte;
// the length saturates at 1480 for the IP total length. The header checksum
// is pre-summed on input and folded while the header plays out. Source MAC
// (index 0) and source IP (index 1): the user writes them on the config channel
// only while the block is idle, not enforced by the block; both reset to zero.
module ipv4_multicast_frame_encapsulator #(
  parameter int unsigned MAX_PAYLOAD = ipmfe_pkg::MAX_PAYLOAD
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ipmfe_cfg_if.sink   cfg_i,
  ipmfe_in_if.sink    in_i,
  ipmfe_out_if.source out_o
);
  import ipmfe_pkg::*;

  logic [MAC_W-1:0]  src_mac_q;
  logic [IP_W-1:0]   src_ip_q;

  logic              hold_vld_q, hold_vld_d;
  logic [BYTE_W-1:0] hold_byte_q;
  logic              hold_last_q;
  hdr_fields_t       fields_q, fields_d;

  logic              inside_q, inside_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;

  logic              out_vld_q, out_vld_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_hdr_q, out_hdr_d;
  logic              out_last_q, out_last_d;

  logic              in_fire;
  logic              out_free;
  logic              emit;
  logic              hdr_phase;
  logic              consume;
  logic [LEN_W-1:0]  sat_len;
  logic [BYTE_W-1:0] hdr_byte;

  // config
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_mac_q <= '0;
      src_ip_q  <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_SOURCE_MAC: src_mac_q <= cfg_i.data[MAC_W-1:0];
        CFG_SOURCE_IP:  src_ip_q  <= cfg_i.data[IP_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free  = !out_vld_q || out_o.ready;
  assign emit      = hold_vld_q && out_free;
  assign hdr_phase = !inside_q && (hcnt_q != HCNT_W'(HDR_BYTES));
  assign consume   = emit && !hdr_phase;
  assign in_i.ready = !hold_vld_q || consume;
  assign in_fire   = in_i.valid && in_i.ready;

  // pre-sum of the checksum words known at input
  always_comb begin
    sat_len = (in_i.payload_length > LEN_W'(MAX_PAYLOAD)) ?
              LEN_W'(MAX_PAYLOAD) : in_i.payload_length;
    fields_d.total_len = sat_len + LEN_W'(IP_HDR_LEN);
    fields_d.packet_id = in_i.packet_id;
    fields_d.part_sum  = CONST_SUM + SUM_W'(fields_d.total_len) +
                         SUM_W'(in_i.packet_id) + SUM_W'(src_ip_q[31:16]) +
                         SUM_W'(src_ip_q[15:0]);
  end

  ipmfe_hdr_mux u_hdr_mux (
    .idx_i     (hcnt_q),
    .src_mac_i (src_mac_q),
    .src_ip_i  (src_ip_q),
    .fields_i  (fields_q),
    .byte_o    (hdr_byte)
  );

  always_comb begin
    hold_vld_d = hold_vld_q;
    if (in_fire) begin
      hold_vld_d = 1'b1;
    end else if (consume) begin
      hold_vld_d = 1'b0;
    end
  end

  always_comb begin
    inside_d = inside_q;
    hcnt_d   = hcnt_q;
    if (consume) begin
      inside_d = !hold_last_q;
      hcnt_d   = '0;
    end else if (emit) begin
      hcnt_d = hcnt_q + HCNT_W'(1);
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_byte_d = out_byte_q;
    out_hdr_d  = out_hdr_q;
    out_last_d = out_last_q;
    if (emit) begin
      out_vld_d  = 1'b1;
      out_byte_d = hdr_phase ? hdr_byte : hold_byte_q;
      out_hdr_d  = hdr_phase;
      out_last_d = !hdr_phase && hold_last_q;
    end else if (out_free) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_vld_q <= 1'b0;
      inside_q   <= 1'b0;
      hcnt_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      hold_vld_q <= hold_vld_d;
      inside_q   <= inside_d;
      hcnt_q     <= hcnt_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      hold_byte_q <= in_i.payload_byte;
      hold_last_q <= in_i.last_in;
      if (!(hold_vld_q && !hold_last_q) && !(inside_q && !hold_vld_q)) begin
        fields_q <= fields_d;
      end
    end
    out_byte_q <= out_byte_d;
    out_hdr_q  <= out_hdr_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.frame_byte = out_byte_q;
  assign out_o.is_header  = out_hdr_q;
  assign out_o.last_out   = out_last_q;

`ifndef SYNTHESIS
  a_hcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HCNT_W'(HDR_BYTES))
    else $error("header counter past end of header");

  a_inside_no_hdr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inside_q |-> hcnt_q == '0)
    else $error("header counter running inside a packet");

  a_hdr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_hdr_q |-> !out_last_q)
    else $error("last flag on a header beat");

  a_hold_until_hdr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold_vld_q && hdr_phase |=> hold_vld_q)
    else $error("first payload beat dropped before header finished");
`endif

endmodule

/* test/ipmfe_frame_checker.sv */
`timescale 1ns / 1ps

module ipmfe_frame_checker
  import ipmfe_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  ipmfe_cfg_if        cfg_i,
  ipmfe_in_if         in_i,
  ipmfe_out_if        out_i,
  output int unsigned mismatch_count_o,
  output int unsigned frames_pending_o
);

  localparam logic [47:0] MCAST_MAC   = 48'h01_00_5e_00_00_05;
  localparam logic [31:0] MCAST_GROUP = 32'he0_00_00_05;
  localparam int unsigned PAYLOAD_CAP = 1480;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       is_header;
    logic       last_out;
  } frame_beat_t;

  frame_beat_t      frame_q[$];
  logic [MAC_W-1:0] src_mac;
  logic [IP_W-1:0]  src_ip;
  logic             in_packet;

  // full ethernet + ipv4 header, first byte in the top bits
  function automatic logic [8*34-1:0] encap_header(logic [10:0] len, logic [15:0] id);
    logic [15:0] total;
    logic [31:0] acc;
    logic [15:0] csum;
    total = 16'd20 + ((len > 11'(PAYLOAD_CAP)) ? 16'(PAYLOAD_CAP) : 16'(len));
    acc = 32'h45c0 + 32'(total) + 32'(id) + 32'h0000 + 32'h0159 +
          32'(src_ip[31:16]) + 32'(src_ip[15:0]) +
          32'(MCAST_GROUP[31:16]) + 32'(MCAST_GROUP[15:0]);
    acc = (acc >> 16) + (acc & 32'hffff);
    acc = acc + (acc >> 16);
    csum = ~acc[15:0];
    return {MCAST_MAC, src_mac, 16'h0800, 8'h45, 8'hc0, total, id, 16'h0000,
            8'h01, 8'h59, csum, src_ip, MCAST_GROUP};
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    frame_beat_t       exp;
    logic [8*34-1:0]   hdr;
    if (!rst_ni) begin
      src_mac          = '0;
      src_ip           = '0;
      in_packet        = 1'b0;
      frame_q.delete();
      mismatch_count_o = 0;
      frames_pending_o = 0;
    end else begin
      if (out_i.valid && out_i.ready) begin
        if (frame_q.size() == 0) begin
          $error("frame beat with nothing expected: frame_byte %02h is_header %0b last_out %0b",
                 out_i.frame_byte, out_i.is_header, out_i.last_out);
          mismatch_count_o++;
        end else begin
          exp = frame_q.pop_front();
          if (out_i.frame_byte !== exp.frame_byte) begin
            $error("frame_byte expected %02h actual %02h", exp.frame_byte, out_i.frame_byte);
            mismatch_count_o++;
          end
          if (out_i.is_header !== exp.is_header) begin
            $error("is_header expected %0b actual %0b", exp.is_header, out_i.is_header);
            mismatch_count_o++;
          end
          if (out_i.last_out !== exp.last_out) begin
            $error("last_out expected %0b actual %0b", exp.last_out, out_i.last_out);
            mismatch_count_o++;
          end
        end
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_SOURCE_MAC) begin
          src_mac = cfg_i.data[MAC_W-1:0];
        end else if (cfg_i.index == CFG_SOURCE_IP) begin
          src_ip = cfg_i.data[IP_W-1:0];
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (!in_packet) begin
          hdr = encap_header(in_i.payload_length, in_i.packet_id);
          for (int i = 0; i < 34; i++) begin
            frame_q.push_back('{hdr[8*(33-i) +: 8], 1'b1, 1'b0});
          end
        end
        frame_q.push_back('{in_i.payload_byte, 1'b0, in_i.last_in});
        in_packet = !in_i.last_in;
      end
      frames_pending_o = frame_q.size();
    end
  end

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import ipmfe_pkg::*;

  localparam int unsigned IDLE_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatch_count;
  int unsigned frames_pending;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  logic [15:0] ready_pattern = 16'hffff;
  int unsigned pattern_pos = 0;

  ipmfe_cfg_if cfg_bus ();
  ipmfe_in_if  in_bus ();
  ipmfe_out_if out_bus ();

  ipv4_multicast_frame_encapsulator u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_bus),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  ipmfe_frame_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_i            (cfg_bus),
    .in_i             (in_bus),
    .out_i            (out_bus),
    .mismatch_count_o (mismatch_count),
    .frames_pending_o (frames_pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // receiver stall pattern, reshuffled whenever the low byte of pattern_pos is zero
  always @(negedge clk) begin
    if (pattern_pos[7:0] == 8'd0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hffff;
        1: ready_pattern = 16'($urandom) | 16'h0001;
        2: ready_pattern = 16'h5555;
        default: ready_pattern = 16'($urandom) | 16'($urandom) | 16'h0100;
      endcase
    end
    out_bus.ready <= ready_pattern[pattern_pos[3:0]];
    pattern_pos = pattern_pos + 1;
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_beat(input logic [7:0] b, input logic [LEN_W-1:0] len,
                           input logic [ID_W-1:0] id, input logic last);
    in_bus.valid          <= 1'b1;
    in_bus.payload_byte   <= b;
    in_bus.payload_length <= len;
    in_bus.packet_id      <= id;
    in_bus.last_in        <= last;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    if (burst_left == 0) begin
      in_bus.valid          <= 1'b0;
      in_bus.payload_byte   <= 8'($urandom);
      in_bus.payload_length <= 11'($urandom);
      in_bus.packet_id      <= 16'($urandom);
      in_bus.last_in        <= 1'($urandom);
      repeat ($urandom_range(1, 5)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
    end else begin
      burst_left--;
    end
  endtask

  // length and id only count on the first beat, later beats carry noise there
  task automatic send_packet(input int unsigned n_bytes, input logic [LEN_W-1:0] len,
                             input logic [ID_W-1:0] id);
    for (int unsigned k = 0; k < n_bytes; k++) begin
      send_beat(8'($urandom), (k == 0) ? len : 11'($urandom), (k == 0) ? id : 16'($urandom),
                k == n_bytes - 1);
    end
  endtask

  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    while (frames_pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned       beats;
    int unsigned       n_bytes;
    logic [LEN_W-1:0]  len;
    logic [MAC_W-1:0]  mac_val;
    logic [IP_W-1:0]   ip_val;
    rst_n                 = 1'b0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.index         = CFG_SOURCE_MAC;
    cfg_bus.data          = '0;
    in_bus.valid          = 1'b0;
    in_bus.payload_byte   = '0;
    in_bus.payload_length = '0;
    in_bus.packet_id      = '0;
    in_bus.last_in        = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed beats on reset register values
    send_beat(8'h00, 11'd1, 16'h0000, 1'b1);
    send_beat(8'hff, 11'd0, 16'hffff, 1'b1);
    send_beat(8'h5a, 11'd1480, 16'h8001, 1'b0);
    send_beat(8'ha5, 11'd3, 16'h1111, 1'b1);
    send_beat(8'h01, 11'd1481, 16'h7ffe, 1'b1);
    send_beat(8'h80, 11'h7ff, 16'hfffe, 1'b0);
    send_beat(8'h7f, 11'h000, 16'h0000, 1'b0);
    send_beat(8'h3c, 11'h7ff, 16'hffff, 1'b1);
    send_packet(3, 11'd10, 16'h4321);
    send_packet(2, 11'd1024, 16'h00ff);
    send_packet(5, 11'd5, 16'hffff);

    for (int s = 0; s < 5; s++) begin
      wait_drained();
      case (s)
        0: begin
          mac_val = '1;
          ip_val  = '1;
        end
        1: begin
          mac_val = '0;
          ip_val  = '0;
        end
        3: begin
          mac_val = 48'haaaa_aaaa_aaaa;
          ip_val  = 32'h5555_5555;
        end
        default: begin
          mac_val = 48'({$urandom, $urandom});
          ip_val  = 32'($urandom);
        end
      endcase
      write_reg(CFG_SOURCE_MAC, mac_val);
      write_reg(CFG_SOURCE_IP, {16'($urandom), ip_val});
      beats = 0;
      while (beats < 16) begin
        n_bytes = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        len = ($urandom_range(0, 9) < 7) ? 11'(n_bytes) : 11'($urandom);
        send_packet(n_bytes, len, 16'($urandom));
        beats += n_bytes;
      end
    end

    wait_drained();
    repeat (10) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
